>>> rtl/mdp_pkg.sv
// shared types, codes and helpers of the method descriptor parser
package mdp_pkg;

  localparam int MAX_PARAMS = 255;
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;
  localparam logic [7:0] CH_VOID  = 8'h56;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_OBJ   = 8'h4C;
  localparam logic [7:0] CH_ARR   = 8'h5B;

  typedef enum logic [2:0] {
    PH_OPEN   = 3'd0,
    PH_PARAMS = 3'd1,
    PH_PNAME  = 3'd2,
    PH_RET    = 3'd3,
    PH_RNAME  = 3'd4,
    PH_DONE   = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    KIND_PARAM = 2'd0,
    KIND_RET   = 2'd1,
    KIND_ERR   = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] type_tag;
    logic [7:0] param_index;
    logic       end_of_descriptor;
  } result_t;

  function automatic logic is_primitive(input logic [7:0] c);
    return c == 8'h42 || c == 8'h43 || c == 8'h44 || c == 8'h46 ||
           c == 8'h49 || c == 8'h4A || c == 8'h53 || c == 8'h5A;
  endfunction

endpackage

>>> rtl/mdp_front.sv
// front end: classifies each character and advances the descriptor state
module mdp_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  logic [7:0]       char_code,
  input  logic             is_last,
  output logic             wr_en,
  output mdp_pkg::result_t wr_data
);
  import mdp_pkg::*;

  phase_t     phase_r, phase_nxt;
  logic       arr_r, arr_nxt;
  logic [7:0] count_r, count_nxt;
  logic       err_r, err_nxt;

  logic       cmp_par, cmp_ret, err_set, set_arr;
  logic       overflow, have;
  phase_t     ph_cls;
  logic [7:0] done_tag, tag;

  // character classification
  always_comb begin
    cmp_par  = 1'b0;
    cmp_ret  = 1'b0;
    err_set  = 1'b0;
    set_arr  = 1'b0;
    done_tag = char_code;
    ph_cls   = phase_r;
    case (phase_r)
      PH_OPEN: begin
        if (char_code == CH_OPEN) ph_cls = PH_PARAMS;
        else err_set = 1'b1;
      end
      PH_PARAMS: begin
        if (char_code == CH_CLOSE && !arr_r) ph_cls = PH_RET;
        else if (is_primitive(char_code)) cmp_par = 1'b1;
        else if (char_code == CH_OBJ) ph_cls = PH_PNAME;
        else if (char_code == CH_ARR) set_arr = 1'b1;
        else err_set = 1'b1;
      end
      PH_PNAME: begin
        if (char_code == CH_SEMI) begin
          cmp_par  = 1'b1;
          done_tag = CH_OBJ;
          ph_cls   = PH_PARAMS;
        end
      end
      PH_RET: begin
        if (is_primitive(char_code) || (char_code == CH_VOID && !arr_r)) cmp_ret = 1'b1;
        else if (char_code == CH_OBJ) ph_cls = PH_RNAME;
        else if (char_code == CH_ARR) set_arr = 1'b1;
        else err_set = 1'b1;
      end
      PH_RNAME: begin
        if (char_code == CH_SEMI) begin
          cmp_ret  = 1'b1;
          done_tag = CH_OBJ;
        end
      end
      default: err_set = 1'b1;
    endcase
    overflow = cmp_par && (count_r >= 8'(MAX_PARAMS));
    have     = !err_r && ((cmp_par && !overflow) || cmp_ret);
    tag      = arr_r ? CH_ARR : done_tag;
  end

  // next state
  always_comb begin
    phase_nxt = phase_r;
    arr_nxt   = arr_r;
    count_nxt = count_r;
    err_nxt   = err_r;
    if (accept) begin
      if (is_last) begin
        phase_nxt = PH_OPEN;
        arr_nxt   = 1'b0;
        count_nxt = '0;
        err_nxt   = 1'b0;
      end else if (!err_r) begin
        phase_nxt = cmp_ret ? PH_DONE : ph_cls;
        err_nxt   = err_set | overflow;
        if (have) arr_nxt = 1'b0;
        else if (set_arr) arr_nxt = 1'b1;
        if (have && cmp_par) count_nxt = count_r + 8'd1;
      end
    end
  end

  // result
  always_comb begin
    wr_en   = accept && (is_last || have);
    wr_data = '{kind: KIND_PARAM, type_tag: tag, param_index: count_r,
                end_of_descriptor: is_last};
    if (cmp_ret) begin
      wr_data.kind        = KIND_RET;
      wr_data.param_index = '0;
    end
    if (is_last && !(have && cmp_ret)) begin
      wr_data.kind        = KIND_ERR;
      wr_data.type_tag    = '0;
      wr_data.param_index = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_OPEN;
      arr_r   <= 1'b0;
      count_r <= '0;
      err_r   <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      arr_r   <= arr_nxt;
      count_r <= count_nxt;
      err_r   <= err_nxt;
    end
  end

endmodule

>>> rtl/mdp_queue.sv
// back end: result queue between the parser and the result ports
module mdp_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  mdp_pkg::result_t wr_data,
  output logic             full,
  input  logic             rd_en,
  output mdp_pkg::result_t rd_data,
  output logic             empty
);
  import mdp_pkg::*;

  result_t             mem_r [QDEPTH];
  logic [QPTR_W-1:0]   wp_r, wp_nxt;
  logic [QPTR_W-1:0]   rp_r, rp_nxt;
  logic [QCNT_W-1:0]   cnt_r, cnt_nxt;
  logic                do_wr, do_rd;

  assign full    = cnt_r == QCNT_W'(QDEPTH);
  assign empty   = cnt_r == '0;
  assign rd_data = mem_r[rp_r];
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;

  always_comb begin
    wp_nxt  = do_wr ? wp_r + QPTR_W'(1) : wp_r;
    rp_nxt  = do_rd ? rp_r + QPTR_W'(1) : rp_r;
    cnt_nxt = cnt_r + QCNT_W'(do_wr) - QCNT_W'(do_rd);
  end

  always_ff @(posedge clk) begin
    if (do_wr) mem_r[wp_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

>>> rtl/method_descriptor_parser_top.sv
// top level of the method descriptor parser
// one character accepted per cycle while in_full is low; its result, if any, is
// written into the result queue and shows on the out ports once earlier results are popped
// the four-entry result queue sets in_full only while four results wait
// synchronous active-low reset returns the parser to expect '(' and empties the queue
module method_descriptor_parser_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  output logic       in_full,
  input  logic [7:0] in_char_code,
  input  logic       in_is_last,
  output logic       out_empty,
  input  logic       out_pop,
  output logic [1:0] out_kind,
  output logic [7:0] out_type_tag,
  output logic [7:0] out_param_index,
  output logic       out_end_of_descriptor
);
  import mdp_pkg::*;

  logic    accept;
  logic    wr_en;
  result_t wr_data;
  result_t rd_data;

  assign accept = in_push && !in_full;

  mdp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .char_code (in_char_code),
    .is_last   (in_is_last),
    .wr_en     (wr_en),
    .wr_data   (wr_data)
  );

  mdp_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (wr_en),
    .wr_data (wr_data),
    .full    (in_full),
    .rd_en   (out_pop),
    .rd_data (rd_data),
    .empty   (out_empty)
  );

  assign out_kind              = rd_data.kind;
  assign out_type_tag          = rd_data.type_tag;
  assign out_param_index       = rd_data.param_index;
  assign out_end_of_descriptor = rd_data.end_of_descriptor;

endmodule

>>> rtl/mdp_checker.sv
// port-level checker for the method descriptor parser, bound to the top level
module mdp_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_empty,
  input logic       out_pop,
  input logic [1:0] out_kind,
  input logic [7:0] out_type_tag,
  input logic [7:0] out_param_index,
  input logic       out_end_of_descriptor
);
  import mdp_pkg::*;

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("queue not empty after reset");

  a_err_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_kind == KIND_ERR) |->
      (out_type_tag == 8'h00 && out_param_index == 8'h00 && out_end_of_descriptor))
    else $error("malformed result with bad fields");

  a_ret_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_kind == KIND_RET) |-> out_param_index == 8'h00)
    else $error("return result with nonzero index");

  a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_kind == KIND_PARAM || out_kind == KIND_RET || out_kind == KIND_ERR))
    else $error("undefined result kind");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_kind) && $stable(out_type_tag)))
    else $error("waiting result changed");

endmodule

bind method_descriptor_parser_top mdp_checker u_mdp_checker (.*);

>>> tb/sv/method_descriptor_parser_checker.sv
// checker for the method descriptor parser: predicts results per beat and compares them
module method_descriptor_parser_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  input  logic       in_full,
  input  logic [7:0] in_char_code,
  input  logic       in_is_last,
  input  logic       out_empty,
  input  logic       out_pop,
  input  logic [1:0] out_kind,
  input  logic [7:0] out_type_tag,
  input  logic [7:0] out_param_index,
  input  logic       out_end_of_descriptor,
  output int         mismatch_count,
  output int         outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import mdp_pkg::*;

  result_t    expected_results[$];
  phase_t     parse_phase;
  logic       in_array;
  logic [7:0] param_total;
  logic       bad_seen;

  function automatic logic base_letter(input logic [7:0] c);
    case (c)
      "B", "C", "D", "F", "I", "J", "S", "Z": return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  task automatic restart_descriptor();
    parse_phase = PH_OPEN;
    in_array    = 1'b0;
    param_total = 8'd0;
    bad_seen    = 1'b0;
  endtask

  task automatic enqueue_expected(input result_t r);
    expected_results = {expected_results, r};
  endtask

  task automatic predict_char(input logic [7:0] c, input logic last);
    result_t    r;
    logic       have;
    logic       param_done;
    logic       ret_done;
    logic [7:0] done_tag;
    r          = '0;
    have       = 1'b0;
    param_done = 1'b0;
    ret_done   = 1'b0;
    done_tag   = 8'd0;
    if (!bad_seen) begin
      case (parse_phase)
        PH_OPEN: begin
          if (c == CH_OPEN) parse_phase = PH_PARAMS;
          else bad_seen = 1'b1;
        end
        PH_PARAMS: begin
          if (c == CH_CLOSE && !in_array) parse_phase = PH_RET;
          else if (base_letter(c)) begin
            done_tag   = c;
            param_done = 1'b1;
          end else if (c == CH_OBJ) parse_phase = PH_PNAME;
          else if (c == CH_ARR) in_array = 1'b1;
          else bad_seen = 1'b1;
        end
        PH_PNAME: begin
          if (c == CH_SEMI) begin
            done_tag    = CH_OBJ;
            param_done  = 1'b1;
            parse_phase = PH_PARAMS;
          end
        end
        PH_RET: begin
          if (base_letter(c) || (c == CH_VOID && !in_array)) begin
            done_tag = c;
            ret_done = 1'b1;
          end else if (c == CH_OBJ) parse_phase = PH_RNAME;
          else if (c == CH_ARR) in_array = 1'b1;
          else bad_seen = 1'b1;
        end
        PH_RNAME: begin
          if (c == CH_SEMI) begin
            done_tag = CH_OBJ;
            ret_done = 1'b1;
          end
        end
        default: bad_seen = 1'b1;
      endcase

      if (param_done) begin
        if (param_total >= 8'(MAX_PARAMS)) begin
          bad_seen = 1'b1;
        end else begin
          r.kind        = KIND_PARAM;
          r.type_tag    = in_array ? CH_ARR : done_tag;
          r.param_index = param_total;
          param_total   = param_total + 8'd1;
          in_array      = 1'b0;
          have          = 1'b1;
        end
      end else if (ret_done) begin
        r.kind        = KIND_RET;
        r.type_tag    = in_array ? CH_ARR : done_tag;
        r.param_index = 8'd0;
        in_array      = 1'b0;
        parse_phase   = PH_DONE;
        have          = 1'b1;
      end
    end

    if (last) begin
      if (bad_seen || parse_phase != PH_DONE || !have || r.kind != KIND_RET) begin
        r.kind        = KIND_ERR;
        r.type_tag    = 8'd0;
        r.param_index = 8'd0;
      end
      r.end_of_descriptor = 1'b1;
      enqueue_expected(r);
      restart_descriptor();
    end else if (have) begin
      r.end_of_descriptor = 1'b0;
      enqueue_expected(r);
    end
  endtask

  initial begin
    mismatch_count = 0;
    outstanding    = 0;
    restart_descriptor();
  end

  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      restart_descriptor();
      expected_results.delete();
    end else begin
      if (out_pop && !out_empty) begin
        if (expected_results.size() == 0) begin
          $error("result beat with nothing expected: kind %0d, type_tag %0h", out_kind,
                 out_type_tag);
          mismatch_count++;
        end else begin
          want = expected_results.pop_front();
          if (out_kind !== want.kind) begin
            $error("kind: expected %0d, actual %0d", want.kind, out_kind);
            mismatch_count++;
          end
          if (out_type_tag !== want.type_tag) begin
            $error("type_tag: expected %0h, actual %0h", want.type_tag, out_type_tag);
            mismatch_count++;
          end
          if (out_param_index !== want.param_index) begin
            $error("param_index: expected %0d, actual %0d", want.param_index,
                   out_param_index);
            mismatch_count++;
          end
          if (out_end_of_descriptor !== want.end_of_descriptor) begin
            $error("end_of_descriptor: expected %0b, actual %0b", want.end_of_descriptor,
                   out_end_of_descriptor);
            mismatch_count++;
          end
        end
      end
      if (in_push && !in_full) predict_char(in_char_code, in_is_last);
    end
    outstanding = expected_results.size();
  end

endmodule

>>> tb/sv/method_descriptor_parser_top_tb.sv
// testbench top: drives descriptors into the parser and gives the verdict
module method_descriptor_parser_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mdp_pkg::*;

  localparam int PHASE_BEATS = 370;
  localparam int LONG_HOLD   = 300;
  localparam logic [7:0] BASE_LETTERS [8] = '{"B", "C", "D", "F", "I", "J", "S", "Z"};

  logic       clk;
  logic       rst_n;
  logic       in_push;
  logic       in_full;
  logic [7:0] in_char_code;
  logic       in_is_last;
  logic       out_empty;
  logic       out_pop;
  logic [1:0] out_kind;
  logic [7:0] out_type_tag;
  logic [7:0] out_param_index;
  logic       out_end_of_descriptor;

  int         mismatch_count;
  int         outstanding;
  int         send_idle_pct;
  int         recv_stall_pct;
  bit         long_hold_req;
  int         beats_sent;
  logic [7:0] desc_bytes[$];

  method_descriptor_parser_top dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_push              (in_push),
    .in_full              (in_full),
    .in_char_code         (in_char_code),
    .in_is_last           (in_is_last),
    .out_empty            (out_empty),
    .out_pop              (out_pop),
    .out_kind             (out_kind),
    .out_type_tag         (out_type_tag),
    .out_param_index      (out_param_index),
    .out_end_of_descriptor(out_end_of_descriptor)
  );

  method_descriptor_parser_checker checker_i (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_push              (in_push),
    .in_full              (in_full),
    .in_char_code         (in_char_code),
    .in_is_last           (in_is_last),
    .out_empty            (out_empty),
    .out_pop              (out_pop),
    .out_kind             (out_kind),
    .out_type_tag         (out_type_tag),
    .out_param_index      (out_param_index),
    .out_end_of_descriptor(out_end_of_descriptor),
    .mismatch_count       (mismatch_count),
    .outstanding          (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    int hold_count;
    out_pop <= 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        out_pop <= 1'b0;
        hold_count = 0;
        while (hold_count < LONG_HOLD) begin
          @(posedge clk);
          hold_count++;
        end
        long_hold_req = 1'b0;
      end else begin
        out_pop <= !(recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct);
      end
    end
  end

  task automatic append_byte(input logic [7:0] b);
    desc_bytes = {desc_bytes, b};
  endtask

  task automatic send_beat(input logic [7:0] c, input logic last);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push      <= 1'b1;
    in_char_code <= c;
    in_is_last   <= last;
    do @(posedge clk); while (in_full);
    beats_sent++;
  endtask

  task automatic send_descriptor();
    for (int i = 0; i < desc_bytes.size(); i++)
      send_beat(desc_bytes[i], i == desc_bytes.size() - 1);
  endtask

  task automatic drain_results();
    in_push <= 1'b0;
    @(posedge clk);
    wait (outstanding == 0);
    @(posedge clk);
  endtask

  task automatic add_field(input bit for_return, input bit plain);
    int         depth;
    int         name_len;
    logic [7:0] b;
    depth = 0;
    if (!plain && $urandom_range(9) >= 7) depth = $urandom_range(1, 3);
    repeat (depth) append_byte(CH_ARR);
    if (for_return && depth == 0 && $urandom_range(3) == 0) begin
      append_byte(CH_VOID);
    end else if (plain || $urandom_range(9) < 5) begin
      append_byte(BASE_LETTERS[$urandom_range(7)]);
    end else begin
      append_byte(CH_OBJ);
      name_len = $urandom_range(4);
      repeat (name_len) begin
        do b = 8'($urandom_range(255)); while (b == CH_SEMI);
        append_byte(b);
      end
      append_byte(CH_SEMI);
    end
  endtask

  task automatic build_descriptor(input int n_params, input bit plain);
    desc_bytes.delete();
    append_byte(CH_OPEN);
    repeat (n_params) add_field(1'b0, plain);
    append_byte(CH_CLOSE);
    add_field(1'b1, plain);
  endtask

  task automatic corrupt_descriptor();
    int keep;
    int n_noise;
    case ($urandom_range(4))
      0: desc_bytes[$urandom_range(desc_bytes.size() - 1)] = 8'($urandom_range(255));
      1: desc_bytes[$urandom_range(desc_bytes.size() - 1)] = CH_VOID;
      2: begin
        keep = (desc_bytes.size() > 1) ? $urandom_range(1, desc_bytes.size() - 1) : 1;
        while (desc_bytes.size() > keep) void'(desc_bytes.pop_back());
      end
      3: repeat ($urandom_range(1, 3)) append_byte(8'($urandom_range(255)));
      default: begin
        desc_bytes.delete();
        n_noise = $urandom_range(1, 6);
        if ($urandom_range(1) == 0) append_byte(CH_OPEN);
        repeat (n_noise) append_byte(8'($urandom_range(255)));
      end
    endcase
  endtask

  task automatic random_descriptor();
    int n_params;
    n_params = ($urandom_range(19) == 0) ? $urandom_range(7, 20) : $urandom_range(0, 5);
    build_descriptor(n_params, 1'b0);
    if ($urandom_range(99) < 15) corrupt_descriptor();
    send_descriptor();
  endtask

  initial begin
    int phase_goal;
    rst_n          <= 1'b0;
    in_push        <= 1'b0;
    in_char_code   <= 8'd0;
    in_is_last     <= 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    long_hold_req  = 1'b0;
    beats_sent     = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    desc_bytes = '{CH_OPEN, CH_CLOSE, CH_VOID};
    send_descriptor();
    desc_bytes = '{CH_OPEN, CH_OBJ, CH_SEMI, CH_ARR, CH_ARR, "I", CH_CLOSE,
                   CH_OBJ, 8'h00, 8'hFF, CH_SEMI};
    send_descriptor();
    desc_bytes = '{CH_OPEN, CH_ARR, CH_VOID, CH_CLOSE, CH_VOID};
    send_descriptor();
    desc_bytes = '{CH_OPEN, "I"};
    send_descriptor();
    desc_bytes = '{CH_OPEN, CH_CLOSE, CH_VOID, "I"};
    send_descriptor();
    drain_results();

    for (int phase_idx = 0; phase_idx < 4; phase_idx++) begin
      case (phase_idx)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
          long_hold_req  = 1'b1;
        end
        1: begin
          send_idle_pct  = 48;
          recv_stall_pct = 0;
          build_descriptor(MAX_PARAMS, 1'b1);
          send_descriptor();
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 48;
          build_descriptor(MAX_PARAMS + 1, 1'b1);
          send_descriptor();
        end
        default: begin
          send_idle_pct  = 30;
          recv_stall_pct = 30;
        end
      endcase
      phase_goal = beats_sent + PHASE_BEATS;
      while (beats_sent < phase_goal) random_descriptor();
      drain_results();
    end

    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
